### hdl/t3in_pkg.sv
// Shared types and constants for the top-three influence normaliser.
// Used by t3in_ctrl, t3in_dpath and top3_influence_normalize.
`default_nettype none

package t3in_pkg;

    // Field widths
    localparam int JOINT_W     = 8;
    localparam int WEIGHT_W    = 16;
    localparam int SHARE_W     = 16;
    localparam int VNUM_W      = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 88;

    // Number of entries shown in a result and sequencing widths
    localparam int SHOWN_MAX = 3;
    localparam int IDX_W     = 2;
    localparam int STEP_W    = 4;

    // Parameter defaults
    localparam int KEEP_COUNT_DEF   = 3;
    localparam int JOINT_LIMIT_DEF  = 256;
    localparam int VERTEX_LIMIT_DEF = 65536;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_STEP,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             accept;
        logic             div_init;
        logic             div_step;
        logic             div_store;
        logic [IDX_W-1:0] idx;
        logic             out_load;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

### hdl/top3_influence_normalize.sv
// Top level of the top-three influence normaliser: stream ports, controller
// and datapath. Depends on t3in_pkg, t3in_ctrl and t3in_dpath.
`default_nettype none

// Takes one vertex's (joint, weight) pairs and keeps the KEEP_COUNT largest
// weights in descending order; when a pair carries tlast, or a transaction
// carries the no-influence flag in tuser, it emits the first three joints and
// their weights divided by the kept sum in Q1.15, truncated, then clears the
// list and advances the vertex count. A pair that does not close a vertex is
// taken back to back with the next. A closing transaction holds the input
// until the single bit-serial restoring divider, which produces one quotient
// bit per cycle and is shared by the shown shares, has worked through them
// and the result is loaded into the output register; there it waits while
// the next vertex's pairs are taken. A zero sum gives zero shares and sets
// the flag in m_axis_tuser.
module top3_influence_normalize
    import t3in_pkg::*;
#(
    parameter int KEEP_COUNT   = KEEP_COUNT_DEF,
    parameter int JOINT_LIMIT  = JOINT_LIMIT_DEF,
    parameter int VERTEX_LIMIT = VERTEX_LIMIT_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] joint_number, [23:8] influence_weight
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tlast,  // vertex_done
    input  wire logic                   s_axis_tuser,  // [0] no_influence
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [15:0] vertex_number, [23:16] joint_first, [31:24] joint_second,
    // [39:32] joint_third, [55:40] share_first, [71:56] share_second,
    // [87:72] share_third
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tuser   // [0] zero_total
);

    t_cmd  cmd;
    t_stat stat;

    t3in_ctrl #(
        .KEEP_COUNT (KEEP_COUNT)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    t3in_dpath #(
        .KEEP_COUNT   (KEEP_COUNT),
        .JOINT_LIMIT  (JOINT_LIMIT),
        .VERTEX_LIMIT (VERTEX_LIMIT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_joint     (s_axis_tdata[JOINT_W-1:0]),
        .i_weight    (s_axis_tdata[JOINT_W+WEIGHT_W-1:JOINT_W]),
        .i_no_infl   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_zero  (m_axis_tuser)
    );

endmodule

`default_nettype wire

### hdl/t3in_ctrl.sv
// Sequencing controller: accepts pairs, runs the shared divider over the
// shown entries and hands the result to the output register. Uses t3in_pkg.
`default_nettype none

module t3in_ctrl
    import t3in_pkg::*;
#(
    parameter int KEEP_COUNT = KEEP_COUNT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire logic  s_axis_tlast,
    input  wire logic  s_axis_tuser,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam int SHOWN_N = (KEEP_COUNT < SHOWN_MAX) ? KEEP_COUNT : SHOWN_MAX;
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(SHOWN_N - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = '1;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [STEP_W-1:0] r_bit, n_bit;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_bit   <= n_bit;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_bit         = r_bit;
        s_axis_tready = 1'b0;
        o_cmd         = '0;
        o_cmd.idx     = r_idx;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                o_cmd.accept  = s_axis_tvalid;
                if (s_axis_tvalid && (s_axis_tlast || s_axis_tuser)) begin
                    n_state = S_INIT;
                    n_idx   = '0;
                end
            end
            S_INIT: begin
                o_cmd.div_init = 1'b1;
                n_bit          = '0;
                n_state        = S_STEP;
            end
            S_STEP: begin
                o_cmd.div_step = 1'b1;
                n_bit          = r_bit + STEP_W'(1);
                if (r_bit == STEP_LAST) begin
                    o_cmd.div_store = 1'b1;
                    if (r_idx == IDX_LAST) begin
                        n_state = S_OUT;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_INIT;
                    end
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_init_to_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_init |=> (r_state == S_STEP) && (r_bit == '0))
        else $error("divider did not start from its first step");
    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after result load");
    a_store_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_store && (r_idx == IDX_LAST)) |=> (r_state == S_OUT))
        else $error("last share stored without moving to output");
`endif

endmodule

`default_nettype wire

### hdl/t3in_dpath.sv
// Datapath: insertion list, running sum, bit-serial divider, vertex counter
// and output register. Driven by t3in_ctrl commands; uses t3in_pkg.
`default_nettype none

module t3in_dpath
    import t3in_pkg::*;
#(
    parameter int KEEP_COUNT   = KEEP_COUNT_DEF,
    parameter int JOINT_LIMIT  = JOINT_LIMIT_DEF,
    parameter int VERTEX_LIMIT = VERTEX_LIMIT_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    input  wire logic [JOINT_W-1:0]     i_joint,
    input  wire logic [WEIGHT_W-1:0]    i_weight,
    input  wire logic                   i_no_infl,
    input  wire logic                   i_out_ready,
    output t_stat                       o_stat,
    output logic                        o_out_valid,
    output logic [OUT_TDATA_W-1:0]      o_out_data,
    output logic                        o_out_zero
);

    localparam int SHOWN_N = (KEEP_COUNT < SHOWN_MAX) ? KEEP_COUNT : SHOWN_MAX;
    localparam int SUM_W   = WEIGHT_W + $clog2(KEEP_COUNT);
    localparam int REM_W   = SUM_W + 1;
    localparam int CNT_W   = $clog2(VERTEX_LIMIT);

    logic [JOINT_W-1:0]  r_kj [KEEP_COUNT];
    logic [WEIGHT_W-1:0] r_kw [KEEP_COUNT];
    logic [JOINT_W-1:0]  n_kj [KEEP_COUNT];
    logic [WEIGHT_W-1:0] n_kw [KEEP_COUNT];
    logic [KEEP_COUNT-1:0] less;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [JOINT_W-1:0]  joint_in;
    logic                insert;

    logic [REM_W-1:0]    r_rem;
    logic [SHARE_W-1:0]  r_quot;
    logic [SHARE_W-1:0]  r_share [SHOWN_MAX];
    logic [WEIGHT_W-1:0] sel_w;
    logic                div_ge;
    logic [REM_W-1:0]    div_diff;

    logic [CNT_W-1:0]    r_vcnt;
    logic [31:0]         vcnt_ext;
    logic                zero_sum;
    logic [JOINT_W-1:0]  show_j [SHOWN_MAX];
    logic [SHARE_W-1:0]  show_s [SHOWN_MAX];

    logic                r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                r_out_zero;

    // Saturate the joint number to the joint range
    always_comb begin
        if (17'(i_joint) >= 17'(JOINT_LIMIT)) begin
            joint_in = JOINT_W'(JOINT_LIMIT - 1);
        end else begin
            joint_in = i_joint;
        end
    end

    assign insert = i_cmd.accept && !i_no_infl;

    // Insertion list: place the pair before the first strictly smaller weight
    for (genvar k = 0; k < KEEP_COUNT; k++) begin : g_list
        assign less[k] = r_kw[k] < i_weight;
        if (k == 0) begin : g_head
            always_comb begin
                n_kj[k] = less[k] ? joint_in : r_kj[k];
                n_kw[k] = less[k] ? i_weight : r_kw[k];
            end
        end else begin : g_body
            always_comb begin
                priority if (less[k] && !less[k-1]) begin
                    n_kj[k] = joint_in;
                    n_kw[k] = i_weight;
                end else if (less[k]) begin
                    n_kj[k] = r_kj[k-1];
                    n_kw[k] = r_kw[k-1];
                end else begin
                    n_kj[k] = r_kj[k];
                    n_kw[k] = r_kw[k];
                end
            end
        end
    end

    // Running sum: add the new weight and drop the one that falls off the end,
    // only when the pair is actually placed in the list
    always_comb begin
        n_sum = r_sum;
        if (less[KEEP_COUNT-1]) begin
            n_sum = r_sum + SUM_W'(i_weight) - SUM_W'(r_kw[KEEP_COUNT-1]);
        end
    end

    // Hold the list and sum; clear them at reset and when a result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            for (int k = 0; k < KEEP_COUNT; k++) begin
                r_kj[k] <= '0;
                r_kw[k] <= '0;
            end
            r_sum <= '0;
        end else if (insert) begin
            r_kj  <= n_kj;
            r_kw  <= n_kw;
            r_sum <= n_sum;
        end
    end

    // Select the weight being divided
    always_comb begin
        sel_w = '0;
        for (int k = 0; k < SHOWN_N; k++) begin
            if (i_cmd.idx == IDX_W'(k)) begin
                sel_w = r_kw[k];
            end
        end
    end

    // One restoring division step: quotient bit and reduced remainder
    assign div_ge   = r_rem >= REM_W'(r_sum);
    assign div_diff = r_rem - REM_W'(r_sum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem  <= REM_W'(sel_w);
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= (div_ge ? div_diff : r_rem) << 1;
            r_quot <= {r_quot[SHARE_W-2:0], div_ge};
        end
        if (i_cmd.div_store) begin
            r_share[i_cmd.idx] <= {r_quot[SHARE_W-2:0], div_ge};
        end
    end

    // Vertex counter, wraps at the vertex limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= '0;
        end else if (i_cmd.out_load) begin
            if (r_vcnt == CNT_W'(VERTEX_LIMIT - 1)) begin
                r_vcnt <= '0;
            end else begin
                r_vcnt <= r_vcnt + CNT_W'(1);
            end
        end
    end

    assign vcnt_ext = 32'(r_vcnt);
    assign zero_sum = (r_sum == '0);

    // Shown joints and shares; entries beyond the list read as zero
    for (genvar i = 0; i < SHOWN_MAX; i++) begin : g_show
        if (i < KEEP_COUNT) begin : g_kept
            assign show_j[i] = r_kj[i];
            assign show_s[i] = zero_sum ? '0 : r_share[i];
        end else begin : g_none
            assign show_j[i] = '0;
            assign show_s[i] = '0;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {show_s[2], show_s[1], show_s[0],
                           show_j[2], show_j[1], show_j[0],
                           vcnt_ext[VNUM_W-1:0]};
            r_out_zero <= zero_sum;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_out_zero      = r_out_zero;

`ifndef ASSERT_OFF
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("result load did not raise output valid");
    a_load_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_sum == '0))
        else $error("kept sum not cleared after result load");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over one not yet taken");
`endif

endmodule

`default_nettype wire
